### hw/rtl/tle_pkg.sv
// Shared types, constants and codes for the text line editor with key repeat.
package tle_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW = $clog2(BUF_DEPTH);
	localparam int CAP_LIMIT_I = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
	localparam logic [8:0] CAP_LIMIT = 9'(CAP_LIMIT_I);

	localparam logic [31:0] FIRST_WAIT_MS = 32'd400;
	localparam logic [31:0] REPEAT_WAIT_MS = 32'd40;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef logic [BUF_AW-1:0] addr_t;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_CAPACITY  = 3'd0,
		REG_MAX_NL    = 3'd1,
		REG_BACKSPACE = 3'd2,
		REG_ENTER     = 3'd3,
		REG_LEFT      = 3'd4,
		REG_RIGHT     = 3'd5,
		REG_DELETE    = 3'd6,
		REG_UNUSED    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_REMOVE,
		ACT_INSERT
	} act_kind_t;

	typedef struct packed {
		logic [8:0]  capacity;
		logic [7:0]  max_newlines;
		logic [15:0] backspace_code;
		logic [15:0] enter_code;
		logic [15:0] left_code;
		logic [15:0] right_code;
		logic [15:0] delete_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  cursor;
		logic [7:0]  length;
		logic [7:0]  newlines;
		logic        prev_valid;
		logic [15:0] prev_key;
		logic [31:0] prev_tick;
		logic        first_press;
	} edit_state_t;

	typedef struct packed {
		logic      pass;
		logic      accepted;
		logic      first_press_next;
		act_kind_t kind;
		logic [7:0] pos;
		logic [7:0] ch;
		logic [7:0] cursor_next;
		logic      newline_inc;
	} key_act_t;

	typedef struct packed {
		logic       insert;
		logic [7:0] pos;
		logic [7:0] length;
		logic [7:0] ch;
	} shift_cmd_t;

	typedef struct packed {
		logic       we;
		addr_t      waddr;
		logic [7:0] wdata;
	} ram_wr_t;

endpackage

### hw/rtl/tle_text_ram.sv
// Character store: one write port and one read port with registered read data.
module tle_text_ram
	import tle_pkg::*;
(
	input  logic       clk,
	input  ram_wr_t    wr,
	input  addr_t      raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tle_key_filter.sv
// Repeat filter and key decoder: decides what one key sample does to the buffer.
module tle_key_filter
	import tle_pkg::*;
(
	input  logic [15:0] key_code,
	input  logic [31:0] tick_ms,
	input  edit_state_t st,
	input  cfg_t        cfg,
	output key_act_t    act
);

	logic        match;
	logic [31:0] elapsed;
	logic [31:0] wait_ms;
	logic [8:0]  cap;
	logic [8:0]  cur9;
	logic [8:0]  len9;

	always_comb begin
		match = st.prev_valid && (st.prev_key == key_code);
		wait_ms = st.first_press ? FIRST_WAIT_MS : REPEAT_WAIT_MS;
		elapsed = tick_ms - st.prev_tick;

		// Clamp the programmed capacity into the range the store supports.
		cap = cfg.capacity;
		if (cap == 9'd0) begin
			cap = 9'd1;
		end else if (cap > CAP_LIMIT) begin
			cap = CAP_LIMIT;
		end
		cur9 = {1'b0, st.cursor};
		len9 = {1'b0, st.length};

		act = '0;
		act.pass = !match || (elapsed >= wait_ms);
		act.accepted = (key_code != 16'd0);
		act.first_press_next = !match;
		act.kind = ACT_NONE;
		act.pos = st.cursor;
		act.ch = key_code[7:0];
		act.cursor_next = st.cursor;

		if (key_code == cfg.backspace_code) begin
			if (st.cursor != 8'd0) begin
				act.kind = ACT_REMOVE;
				act.pos = st.cursor - 8'd1;
				act.cursor_next = st.cursor - 8'd1;
			end
		end else if (key_code == cfg.delete_code) begin
			if (st.cursor < st.length) begin
				act.kind = ACT_REMOVE;
			end
		end else if (key_code == cfg.left_code) begin
			if (st.cursor != 8'd0) begin
				act.cursor_next = st.cursor - 8'd1;
			end
		end else if (key_code == cfg.right_code) begin
			if ((st.cursor < st.length) && ((cur9 + 9'd1) < cap)) begin
				act.cursor_next = st.cursor + 8'd1;
			end
		end else if ((key_code != 16'd0) && ((len9 + 9'd1) < cap)) begin
			if (key_code == cfg.enter_code) begin
				// Enter only inserts while the newline budget lasts.
				if (st.newlines < cfg.max_newlines) begin
					act.kind = ACT_INSERT;
					act.ch = NEWLINE_CHAR;
					act.newline_inc = 1'b1;
					act.cursor_next = st.cursor + 8'd1;
				end
			end else begin
				act.kind = ACT_INSERT;
				act.cursor_next = st.cursor + 8'd1;
			end
		end
	end

endmodule

### hw/rtl/tle_shifter.sv
// Tail shifter: moves the text behind an edit point one entry per cycle.
module tle_shifter
	import tle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  shift_cmd_t cmd,
	input  logic [7:0] rdata,
	output addr_t      raddr,
	output ram_wr_t    wr,
	output logic       busy,
	output logic       done
);

	logic       busy_q;
	logic       insert_q;
	logic [7:0] pos_q;
	logic [7:0] ch_q;
	logic [7:0] rd_q;
	logic [7:0] cnt_q;
	logic       pend_s1;
	logic [7:0] waddr_s1;

	assign busy = busy_q;
	assign raddr = addr_t'(rd_q);
	assign done = busy_q && (cnt_q == 8'd0) && !pend_s1;

	always_comb begin
		wr = '0;
		if (busy_q && pend_s1) begin
			wr.we = 1'b1;
			wr.waddr = addr_t'(waddr_s1);
			wr.wdata = rdata;
		end else if (done && insert_q) begin
			// The new character goes in once the tail has moved out of its way.
			wr.we = 1'b1;
			wr.waddr = addr_t'(pos_q);
			wr.wdata = ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			insert_q <= 1'b0;
			pos_q <= '0;
			ch_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			waddr_s1 <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			insert_q <= cmd.insert;
			pos_q <= cmd.pos;
			ch_q <= cmd.ch;
			pend_s1 <= 1'b0;
			if (cmd.insert) begin
				rd_q <= cmd.length - 8'd1;
				cnt_q <= cmd.length - cmd.pos;
			end else begin
				rd_q <= cmd.pos + 8'd1;
				cnt_q <= cmd.length - cmd.pos - 8'd1;
			end
		end else if (busy_q) begin
			if (cnt_q != 8'd0) begin
				pend_s1 <= 1'b1;
				waddr_s1 <= insert_q ? rd_q + 8'd1 : rd_q - 8'd1;
				rd_q <= insert_q ? rd_q - 8'd1 : rd_q + 8'd1;
				cnt_q <= cnt_q - 8'd1;
			end else begin
				pend_s1 <= 1'b0;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/text_line_editor_key_repeat_unit.sv
// Line editor with typematic repeat: one transaction in, one result transaction out.
// A key that leaves the text alone, a clear or a no-op goes straight to the hold state;
// a read passes the read state first. Insert and delete shift the tail through the
// character RAM, one entry a cycle; that RAM port sets the rate.
// A new transaction is taken while the previous result still waits at the output register.
// Reset clears cursor, length, newline count and the repeat history; the RAM is not cleared.
module text_line_editor_key_repeat_unit
	import tle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // key_code[15:0], tick_ms[47:16], read_index[55:48]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // cursor[7:0], text_length[15:8], read_char[23:16],
	                                    // accepted[24], zero[31:25]
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_HOLD
	} state_t;

	state_t      state_q;
	cfg_t        cfg_q;
	edit_state_t st_q;

	// Pending result, filled while the item is processed.
	logic [7:0]  res_cursor_q;
	logic [7:0]  res_length_q;
	logic [7:0]  res_char_q;
	logic        res_acc_q;
	logic        read_hit_q;

	logic        m_valid_q;
	logic [31:0] m_data_q;

	logic [15:0] in_key;
	logic [31:0] in_tick;
	logic [7:0]  in_index;
	opcode_t     in_op;
	logic        in_fire;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	key_act_t    act;
	shift_cmd_t  shift_cmd;
	logic        shift_start;
	logic        shift_busy;
	logic        shift_done;
	addr_t       shift_raddr;
	ram_wr_t     ram_wr;
	addr_t       ram_raddr;
	logic [7:0]  ram_rdata;
	logic [7:0]  length_next;

	assign in_key = s_axis_tdata[15:0];
	assign in_tick = s_axis_tdata[47:16];
	assign in_index = s_axis_tdata[55:48];
	assign in_op = opcode_t'(s_axis_tuser);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	assign pready = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register readback.
	always_comb begin
		unique case (cfg_idx)
			REG_CAPACITY:  prdata = {23'd0, cfg_q.capacity};
			REG_MAX_NL:    prdata = {24'd0, cfg_q.max_newlines};
			REG_BACKSPACE: prdata = {16'd0, cfg_q.backspace_code};
			REG_ENTER:     prdata = {16'd0, cfg_q.enter_code};
			REG_LEFT:      prdata = {16'd0, cfg_q.left_code};
			REG_RIGHT:     prdata = {16'd0, cfg_q.right_code};
			REG_DELETE:    prdata = {16'd0, cfg_q.delete_code};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= 9'd256;
			cfg_q.max_newlines <= 8'd0;
			cfg_q.backspace_code <= 16'd8;
			cfg_q.enter_code <= 16'd13;
			cfg_q.left_code <= 16'hFF25;
			cfg_q.right_code <= 16'hFF27;
			cfg_q.delete_code <= 16'hFF2E;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAPACITY:  cfg_q.capacity <= pwdata[8:0];
				REG_MAX_NL:    cfg_q.max_newlines <= pwdata[7:0];
				REG_BACKSPACE: cfg_q.backspace_code <= pwdata[15:0];
				REG_ENTER:     cfg_q.enter_code <= pwdata[15:0];
				REG_LEFT:      cfg_q.left_code <= pwdata[15:0];
				REG_RIGHT:     cfg_q.right_code <= pwdata[15:0];
				REG_DELETE:    cfg_q.delete_code <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	tle_key_filter u_filter (
		.key_code (in_key),
		.tick_ms  (in_tick),
		.st       (st_q),
		.cfg      (cfg_q),
		.act      (act)
	);

	// An edit that changes the length hands the tail move to the shifter.
	always_comb begin
		length_next = st_q.length;
		if (act.kind == ACT_REMOVE) begin
			length_next = st_q.length - 8'd1;
		end else if (act.kind == ACT_INSERT) begin
			length_next = st_q.length + 8'd1;
		end
		shift_cmd.insert = (act.kind == ACT_INSERT);
		shift_cmd.pos = act.pos;
		shift_cmd.length = st_q.length;
		shift_cmd.ch = act.ch;
		shift_start = in_fire && (in_op == OP_KEY) && act.pass && (act.kind != ACT_NONE);
	end

	tle_shifter u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (shift_start),
		.cmd    (shift_cmd),
		.rdata  (ram_rdata),
		.raddr  (shift_raddr),
		.wr     (ram_wr),
		.busy   (shift_busy),
		.done   (shift_done)
	);

	// The read port serves the shifter while it runs and the read opcode otherwise.
	assign ram_raddr = shift_busy ? shift_raddr : addr_t'(in_index);

	tle_text_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q.cursor <= '0;
			st_q.length <= '0;
			st_q.newlines <= '0;
			st_q.prev_valid <= 1'b0;
			st_q.prev_key <= '0;
			st_q.prev_tick <= '0;
			st_q.first_press <= 1'b1;
			res_cursor_q <= '0;
			res_length_q <= '0;
			res_char_q <= '0;
			res_acc_q <= 1'b0;
			read_hit_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			// In the hold state the output register is reloaded or kept below.
			if (m_valid_q && m_axis_tready && (state_q != ST_HOLD)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_cursor_q <= st_q.cursor;
						res_length_q <= st_q.length;
						res_char_q <= 8'd0;
						res_acc_q <= 1'b0;
						state_q <= ST_HOLD;
						case (in_op)
							OP_KEY: begin
								// A filtered sample leaves every piece of edit state alone.
								if (act.pass) begin
									st_q.prev_valid <= 1'b1;
									st_q.prev_key <= in_key;
									st_q.prev_tick <= in_tick;
									st_q.first_press <= act.first_press_next;
									st_q.cursor <= act.cursor_next;
									st_q.length <= length_next;
									if (act.newline_inc) begin
										st_q.newlines <= st_q.newlines + 8'd1;
									end
									res_cursor_q <= act.cursor_next;
									res_length_q <= length_next;
									res_acc_q <= act.accepted;
									if (act.kind != ACT_NONE) begin
										state_q <= ST_SHIFT;
									end
								end
							end
							OP_READ: begin
								read_hit_q <= (in_index < st_q.length);
								state_q <= ST_READ;
							end
							OP_CLEAR: begin
								st_q.cursor <= '0;
								st_q.length <= '0;
								st_q.newlines <= '0;
								st_q.prev_valid <= 1'b0;
								st_q.prev_tick <= '0;
								st_q.first_press <= 1'b1;
								res_cursor_q <= '0;
								res_length_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					// RAM data for the requested index arrives in the cycle after the request.
					res_char_q <= read_hit_q ? ram_rdata : 8'd0;
					state_q <= ST_HOLD;
				end
				ST_SHIFT: begin
					if (shift_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q <= {7'd0, res_acc_q, res_char_q, res_length_q, res_cursor_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
